[hw/rtl/hvn_pkg.sv]
// Shared constants for the hashed value noise core.
// Used by the top level, hvn_coord, hvn_hash, hvn_lerp and the testbench; depends on nothing.
package hvn_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int VAL_W      = 21;
    localparam int PIPE_DEPTH = 13;
    // number of hash stages from coordinate stage output to hash output
    localparam int HASH_LAT   = 6;

    localparam logic [63:0] K_MIX1 = 64'hbf58476d1ce4e5b9;
    localparam logic [63:0] K_MIX2 = 64'h94d049bb133111eb;
    localparam logic [63:0] K_SALT = 64'h27d4eb2f165667c5;
    localparam logic [31:0] ADD_X  = 32'h9e3779b9;
    localparam logic [31:0] ADD_Y  = 32'h85ebca6b;
    localparam logic [31:0] ADD_S  = 32'hc2b2ae35;

    typedef enum logic [1:0] {
        REG_SEED = 2'd0,
        REG_SALT = 2'd1,
        REG_FREQ = 2'd2
    } reg_index_t;

endpackage

[hw/rtl/hashed_value_noise_2d_core.sv]
// Top level of the 2D hashed value noise core: config registers and pipeline control.
// Depends on hvn_pkg, hvn_coord, hvn_hash, hvn_lerp.
//
//  channel  | signals                           | transfer when
//  ---------+-----------------------------------+-----------------------------
//  in       | in_valid, in_stall, x/y_coord     | in_valid && !in_stall
//  out      | out_valid, out_stall, noise_value | out_valid && !out_stall
//  cfg      | cfg_wr_en, cfg_index, cfg_data    | cfg_wr_en
//
// One sample per cycle while the result is not stalled; a sample passes through the
// coordinate, hash (with the chained 64-bit finalizer multiplies) and interpolation stages.
// Reset clears the valid bits and loads seed 0, salt 0, frequency 1.0.
// A stalled result freezes the whole pipeline; in_stall follows it.
module hashed_value_noise_2d_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic signed [31:0] x_coord,
    input  logic signed [31:0] y_coord,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [20:0] noise_value,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_data
);

    localparam int F  = hvn_pkg::FRAC_BITS;
    localparam int HL = hvn_pkg::HASH_LAT;

    logic [63:0] seed_reg;
    logic [31:0] salt_reg;
    logic [23:0] freq_reg;
    logic [hvn_pkg::PIPE_DEPTH-1:0] vld_reg;
    logic [F-1:0] sx_dly_reg [HL];
    logic [F-1:0] sy_dly_reg [HL];

    logic        en;
    logic [31:0] hx0;
    logic [31:0] hx1;
    logic [31:0] hy0;
    logic [31:0] hy1;
    logic [F-1:0] sx;
    logic [F-1:0] sy;
    logic [hvn_pkg::VAL_W-1:0] va;
    logic [hvn_pkg::VAL_W-1:0] vb;
    logic [hvn_pkg::VAL_W-1:0] vc;
    logic [hvn_pkg::VAL_W-1:0] vd;

    assign out_valid = vld_reg[hvn_pkg::PIPE_DEPTH-1];
    assign en        = !out_valid || !out_stall;
    assign in_stall  = !en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg <= 64'd0;
            salt_reg <= 32'd0;
            freq_reg <= 24'd65536;
        end
        else if (cfg_wr_en)
        begin
            unique case (hvn_pkg::reg_index_t'(cfg_index))
                hvn_pkg::REG_SEED: seed_reg <= cfg_data;
                hvn_pkg::REG_SALT: salt_reg <= cfg_data[31:0];
                hvn_pkg::REG_FREQ: freq_reg <= cfg_data[23:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[hvn_pkg::PIPE_DEPTH-2:0], in_valid};
        end
    end

    // eased fractions wait alongside the hash stages
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sx_dly_reg[0] <= sx;
            sy_dly_reg[0] <= sy;
            for (int i = 1; i < HL; i++)
            begin
                sx_dly_reg[i] <= sx_dly_reg[i-1];
                sy_dly_reg[i] <= sy_dly_reg[i-1];
            end
        end
    end

    hvn_coord u_cx (
        .clk(clk), .en(en), .coord(x_coord), .freq(freq_reg), .add_k(hvn_pkg::ADD_X),
        .h0(hx0), .h1(hx1), .eased(sx)
    );

    hvn_coord u_cy (
        .clk(clk), .en(en), .coord(y_coord), .freq(freq_reg), .add_k(hvn_pkg::ADD_Y),
        .h0(hy0), .h1(hy1), .eased(sy)
    );

    hvn_hash u_hash (
        .clk(clk), .en(en), .seed(seed_reg), .salt(salt_reg),
        .hx0(hx0), .hx1(hx1), .hy0(hy0), .hy1(hy1),
        .val_a(va), .val_b(vb), .val_c(vc), .val_d(vd)
    );

    hvn_lerp u_lerp (
        .clk(clk), .en(en), .val_a(va), .val_b(vb), .val_c(vc), .val_d(vd),
        .sx(sx_dly_reg[HL-1]), .sy(sy_dly_reg[HL-1]), .result(noise_value)
    );

endmodule

[hw/rtl/hvn_mulk.sv]
// Low 64 bits of a 64x64 product, from three registered 32x32 partials.
// Uses nothing from hvn_pkg; no dependencies.
module hvn_mulk (
    input  logic        clk,
    input  logic        en,
    input  logic [63:0] a,
    input  logic [63:0] k,
    output logic [63:0] y
);

    logic [63:0] ll_reg;
    logic [31:0] lh_reg;
    logic [31:0] hl_reg;
    logic [63:0] ll_next;
    logic [63:0] lh_next;
    logic [63:0] hl_next;

    always_comb
    begin
        ll_next = a[31:0] * k[31:0];
        lh_next = a[31:0] * k[63:32];
        hl_next = a[63:32] * k[31:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ll_reg <= ll_next;
            lh_reg <= lh_next[31:0];
            hl_reg <= hl_next[31:0];
        end
    end

    assign y = ll_reg + {lh_reg + hl_reg, 32'd0};

endmodule

[hw/rtl/hvn_coord.sv]
// Coordinate scaling, lattice corner split and smoothstep easing, 3 stages.
// Depends on hvn_pkg.
module hvn_coord (
    input  logic               clk,
    input  logic               en,
    input  logic signed [31:0] coord,
    input  logic        [23:0] freq,
    input  logic        [31:0] add_k,
    output logic        [31:0] h0,
    output logic        [31:0] h1,
    output logic        [hvn_pkg::FRAC_BITS-1:0] eased
);

    localparam int F = hvn_pkg::FRAC_BITS;

    logic signed [56:0]  p_reg;
    logic [F-1:0]        t2_reg;
    logic [F+1:0]        k_reg;
    logic [31:0]         h0_s2_reg;
    logic [31:0]         h1_s2_reg;
    logic [31:0]         h0_reg;
    logic [31:0]         h1_reg;
    logic [F-1:0]        s_reg;

    logic [31:0]         corner;
    logic [F-1:0]        t;
    logic [2*F-1:0]      tt;
    logic [2*F+1:0]      sprod;

    always_comb
    begin
        // floor of the Q(2F) product, wrapped to 32 bits
        corner = 32'(p_reg >>> (2 * F));
        t      = p_reg[2*F-1:F];
        tt     = t * t;
        sprod  = t2_reg * k_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg     <= coord * $signed({1'b0, freq});
            t2_reg    <= tt[2*F-1:F];
            k_reg     <= (F+2)'(3 << F) - {1'b0, t, 1'b0};
            h0_s2_reg <= corner + add_k;
            h1_s2_reg <= corner + 32'd1 + add_k;
            s_reg     <= sprod[2*F-1:F];
            h0_reg    <= h0_s2_reg;
            h1_reg    <= h1_s2_reg;
        end
    end

    assign h0    = h0_reg;
    assign h1    = h1_reg;
    assign eased = s_reg;

endmodule

[hw/rtl/hvn_hash.sv]
// Corner hashing: term multiplies, seed mix and splitmix64 finalizer, 6 stages.
// Depends on hvn_pkg and hvn_mulk.
module hvn_hash (
    input  logic        clk,
    input  logic        en,
    input  logic [63:0] seed,
    input  logic [31:0] salt,
    input  logic [31:0] hx0,
    input  logic [31:0] hx1,
    input  logic [31:0] hy0,
    input  logic [31:0] hy1,
    output logic [hvn_pkg::VAL_W-1:0] val_a,
    output logic [hvn_pkg::VAL_W-1:0] val_b,
    output logic [hvn_pkg::VAL_W-1:0] val_c,
    output logic [hvn_pkg::VAL_W-1:0] val_d
);

    logic [63:0] tx0;
    logic [63:0] tx1;
    logic [63:0] ty0;
    logic [63:0] ty1;
    logic [63:0] ts;
    logic [63:0] h [4];
    logic [63:0] vb_reg [4];
    logic [63:0] m1 [4];
    logic [63:0] vd_reg [4];
    logic [63:0] m2 [4];
    logic [63:0] v3 [4];
    logic [hvn_pkg::VAL_W-1:0] val_reg [4];

    hvn_mulk u_mx0 (.clk(clk), .en(en), .a({32'd0, hx0}), .k(hvn_pkg::K_MIX1), .y(tx0));
    hvn_mulk u_mx1 (.clk(clk), .en(en), .a({32'd0, hx1}), .k(hvn_pkg::K_MIX1), .y(tx1));
    hvn_mulk u_my0 (.clk(clk), .en(en), .a({32'd0, hy0}), .k(hvn_pkg::K_MIX2), .y(ty0));
    hvn_mulk u_my1 (.clk(clk), .en(en), .a({32'd0, hy1}), .k(hvn_pkg::K_MIX2), .y(ty1));
    hvn_mulk u_ms (
        .clk(clk), .en(en), .a({32'd0, salt + hvn_pkg::ADD_S}), .k(hvn_pkg::K_SALT), .y(ts)
    );

    always_comb
    begin
        // corner order: (x0,y0) (x1,y0) (x0,y1) (x1,y1)
        h[0] = seed ^ tx0 ^ ty0 ^ ts;
        h[1] = seed ^ tx1 ^ ty0 ^ ts;
        h[2] = seed ^ tx0 ^ ty1 ^ ts;
        h[3] = seed ^ tx1 ^ ty1 ^ ts;
    end

    for (genvar i = 0; i < 4; i++)
    begin : g_corner
        hvn_mulk u_f1 (.clk(clk), .en(en), .a(vb_reg[i]), .k(hvn_pkg::K_MIX1), .y(m1[i]));
        hvn_mulk u_f2 (.clk(clk), .en(en), .a(vd_reg[i]), .k(hvn_pkg::K_MIX2), .y(m2[i]));

        assign v3[i] = m2[i] ^ (m2[i] >> 31);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                vb_reg[i]  <= h[i] ^ (h[i] >> 30);
                vd_reg[i]  <= m1[i] ^ (m1[i] >> 27);
                val_reg[i] <= v3[i][31:11];
            end
        end
    end

    assign val_a = val_reg[0];
    assign val_b = val_reg[1];
    assign val_c = val_reg[2];
    assign val_d = val_reg[3];

endmodule

[hw/rtl/hvn_lerp.sv]
// Bilinear interpolation of the four corner values, 4 stages.
// Depends on hvn_pkg.
module hvn_lerp (
    input  logic        clk,
    input  logic        en,
    input  logic [hvn_pkg::VAL_W-1:0]     val_a,
    input  logic [hvn_pkg::VAL_W-1:0]     val_b,
    input  logic [hvn_pkg::VAL_W-1:0]     val_c,
    input  logic [hvn_pkg::VAL_W-1:0]     val_d,
    input  logic [hvn_pkg::FRAC_BITS-1:0] sx,
    input  logic [hvn_pkg::FRAC_BITS-1:0] sy,
    output logic [hvn_pkg::VAL_W-1:0]     result
);

    localparam int F  = hvn_pkg::FRAC_BITS;
    localparam int VW = hvn_pkg::VAL_W;
    localparam int PW = VW + F + 2;

    logic signed [PW-1:0] pt_reg;
    logic signed [PW-1:0] pb_reg;
    logic [VW-1:0]        a_reg;
    logic [VW-1:0]        c_reg;
    logic [F-1:0]         sy1_reg;
    logic [F-1:0]         sy2_reg;
    logic [VW-1:0]        top_reg;
    logic [VW-1:0]        bot_reg;
    logic signed [PW-1:0] py_reg;
    logic [VW-1:0]        top3_reg;
    logic [VW-1:0]        out_reg;

    logic signed [VW:0]   dt;
    logic signed [VW:0]   db;
    logic signed [VW:0]   dy;
    logic signed [PW-1:0] top_sum;
    logic signed [PW-1:0] bot_sum;
    logic signed [PW-1:0] out_sum;

    always_comb
    begin
        dt = $signed({1'b0, val_b}) - $signed({1'b0, val_a});
        db = $signed({1'b0, val_d}) - $signed({1'b0, val_c});
        dy = $signed({1'b0, bot_reg}) - $signed({1'b0, top_reg});
        // arithmetic shift floors, so the result stays between the ends
        top_sum = $signed({{(PW-VW){1'b0}}, a_reg}) + (pt_reg >>> F);
        bot_sum = $signed({{(PW-VW){1'b0}}, c_reg}) + (pb_reg >>> F);
        out_sum = $signed({{(PW-VW){1'b0}}, top3_reg}) + (py_reg >>> F);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pt_reg   <= PW'(dt * $signed({1'b0, sx}));
            pb_reg   <= PW'(db * $signed({1'b0, sx}));
            a_reg    <= val_a;
            c_reg    <= val_c;
            sy1_reg  <= sy;
            top_reg  <= top_sum[VW-1:0];
            bot_reg  <= bot_sum[VW-1:0];
            sy2_reg  <= sy1_reg;
            py_reg   <= PW'(dy * $signed({1'b0, sy2_reg}));
            top3_reg <= top_reg;
            out_reg  <= out_sum[VW-1:0];
        end
    end

    assign result = out_reg;

endmodule

[hw/rtl/hvn_checker.sv]
// Port-level checks for the noise core, bound to the top level.
// Depends only on the top level's ports.
module hvn_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [20:0] noise_value
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(noise_value))
        else $error("stalled result changed");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without a stalled result");

    a_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !out_stall |-> !in_stall)
        else $error("input stalled while output free");

    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_stall |=> in_valid)
        else $error("input transfer withdrawn while stalled");

endmodule

bind hashed_value_noise_2d_core hvn_checker u_hvn_checker (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .noise_value(noise_value)
);

[test/tb_hashed_value_noise_2d_core.sv]
// Testbench for hashed_value_noise_2d_core: random and directed coordinates checked
// against an in-bench fixed-point value noise predictor. Depends on hvn_pkg and the core.
module tb_hashed_value_noise_2d_core;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
    } coord_pair_t;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic signed [31:0] x_coord;
    logic signed [31:0] y_coord;
    logic               out_valid;
    logic               out_stall;
    logic [20:0]        noise_value;
    logic               cfg_wr_en;
    logic [1:0]         cfg_index;
    logic [63:0]        cfg_data;

    // predictor copy of the registers
    logic [63:0] p_seed;
    logic [31:0] p_salt;
    logic [23:0] p_freq;

    coord_pair_t pending_coords[$];
    logic [20:0] expected_noise[$];
    int          errors;
    int          checked;
    longint      cycle_count;
    bit          hold_active;
    int          hold_left;
    bit          hold_request;
    int          in_gap;

    hashed_value_noise_2d_core u_dut (.*);

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic logic [63:0] splitmix_finish(logic [63:0] v);
        v = v ^ (v >> 30);
        v = v * hvn_pkg::K_MIX1;
        v = v ^ (v >> 27);
        v = v * hvn_pkg::K_MIX2;
        v = v ^ (v >> 31);
        return v;
    endfunction

    function automatic logic [20:0] lattice_value(logic [31:0] cx, logic [31:0] cy);
        logic [63:0] h;
        logic [31:0] tx, ty, ts;
        tx = cx + hvn_pkg::ADD_X;
        ty = cy + hvn_pkg::ADD_Y;
        ts = p_salt + hvn_pkg::ADD_S;
        h = p_seed ^ ({32'd0, tx} * hvn_pkg::K_MIX1) ^ ({32'd0, ty} * hvn_pkg::K_MIX2)
            ^ ({32'd0, ts} * hvn_pkg::K_SALT);
        h = splitmix_finish(h);
        return h[31:11];
    endfunction

    // scaled coordinate: 32-bit corner and eased Q0.16 fraction
    function automatic void scale_axis(input logic signed [31:0] c,
                                       output logic [31:0] corner,
                                       output logic [63:0] eased);
        logic signed [63:0] prod;
        logic [63:0] t, t2, k;
        prod = 64'(c) * $signed({40'd0, p_freq});
        corner = prod[63:32];
        t = {48'd0, prod[31:16]};
        t2 = (t * t) >> 16;
        k = (64'd3 << 16) - 2 * t;
        eased = ((t2 * k) >> 16) & 64'hffff;
    endfunction

    function automatic logic [63:0] blend(logic [63:0] a, logic [63:0] b, logic [63:0] s);
        if (b >= a)
            return a + (((b - a) * s) >> 16);
        return a - ((((a - b) * s) + 64'hffff) >> 16);
    endfunction

    function automatic logic [20:0] noise_at(coord_pair_t cp);
        logic [31:0] x0, y0;
        logic [63:0] sx, sy, top, bot, r;
        scale_axis(cp.x, x0, sx);
        scale_axis(cp.y, y0, sy);
        top = blend(lattice_value(x0, y0), lattice_value(x0 + 1, y0), sx);
        bot = blend(lattice_value(x0, y0 + 1), lattice_value(x0 + 1, y0 + 1), sx);
        r = blend(top, bot, sy);
        return r[20:0];
    endfunction

    task automatic report_mismatch(input string what);
        $display("mismatch @%0t: %s", $realtime, what);
        errors++;
    endtask

    // driver: transfers from the pending queue, random gaps
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            x_coord <= '0;
            y_coord <= '0;
            in_gap = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
                expected_noise.push_back(noise_at('{x: x_coord, y: y_coord}));
            if (!in_valid || !in_stall)
            begin
                if (in_gap > 0)
                begin
                    in_gap--;
                    in_valid <= 1'b0;
                end
                else if (pending_coords.size() > 0)
                begin
                    coord_pair_t cp;
                    cp = pending_coords.pop_front();
                    in_valid <= 1'b1;
                    x_coord <= cp.x;
                    y_coord <= cp.y;
                    in_gap = ($urandom_range(0, 99) < 60) ? 0 :
                             ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                          : $urandom_range(1, 3);
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // monitor and receiver stall
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            hold_active <= 1'b0;
            hold_left <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_noise.size() == 0)
                    report_mismatch("result with nothing expected");
                else
                begin
                    logic [20:0] want;
                    want = expected_noise.pop_front();
                    checked++;
                    if (noise_value !== want)
                        report_mismatch($sformatf("noise_value %0d, wanted %0d",
                                                  noise_value, want));
                end
            end
            if (hold_request && !hold_active)
            begin
                hold_active <= 1'b1;
                hold_left <= 200;
                out_stall <= 1'b1;
            end
            else if (hold_active)
            begin
                if (hold_left == 0)
                begin
                    hold_active <= 1'b0;
                    out_stall <= 1'b0;
                end
                else
                    hold_left <= hold_left - 1;
            end
            else if ($urandom_range(0, 99) < 70)
                out_stall <= 1'b0;
            else
                out_stall <= ($urandom_range(0, 9) == 0) ? ($urandom_range(0, 3) != 0) : 1'b1;
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > 400000)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("** hashed_value_noise_2d_core: FAILED **");
            $finish;
        end
    end

    task automatic write_reg(input hvn_pkg::reg_index_t idx, input logic [63:0] value);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        case (idx)
            hvn_pkg::REG_SEED: p_seed = value;
            hvn_pkg::REG_SALT: p_salt = value[31:0];
            hvn_pkg::REG_FREQ: p_freq = value[23:0];
            default: ;
        endcase
    endtask

    task automatic drain();
        while (pending_coords.size() > 0 || in_valid || expected_noise.size() > 0)
            @(posedge clk);
        repeat (hvn_pkg::PIPE_DEPTH + 4) @(posedge clk);
    endtask

    function automatic logic signed [31:0] rand_coord();
        case ($urandom_range(0, 3))
            0: return $urandom();
            1: return $signed($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000;
            2: return {$urandom_range(0, 1) ? 16'hffff : 16'h0000, 16'($urandom())};
            default: return $urandom() & 32'h8000_ffff;
        endcase
    endfunction

    initial
    begin
        logic [63:0] seeds[4];
        logic [63:0] salts[4];
        logic [63:0] freqs[4];
        errors = 0;
        checked = 0;
        cycle_count = 0;
        hold_request = 0;
        p_seed = '0;
        p_salt = '0;
        p_freq = 24'd65536;
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = hvn_pkg::REG_SEED;
        cfg_data = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // directed: field extremes, corner wrap, fraction edges, at reset settings
        pending_coords.push_back('{32'sh7fffffff, 32'sh80000000});
        pending_coords.push_back('{32'sh80000000, 32'sh7fffffff});
        pending_coords.push_back('{32'sh0, 32'sh0});
        pending_coords.push_back('{-32'sh1, -32'sh1});
        pending_coords.push_back('{32'sh0000ffff, 32'sh00008000});
        pending_coords.push_back('{32'sh7fff0000, 32'shffff0000});
        pending_coords.push_back('{32'sh55555555, 32'shaaaaaaaa});
        pending_coords.push_back('{32'shaaaaaaaa, 32'sh55555555});
        drain();
        // largest frequency: products wrap well past 32 bits
        write_reg(hvn_pkg::REG_FREQ, 64'hffff_ffff_ffff_ffff);
        write_reg(hvn_pkg::REG_SEED, 64'hffff_ffff_ffff_ffff);
        write_reg(hvn_pkg::REG_SALT, 64'hffff_ffff_8000_0000);
        pending_coords.push_back('{32'sh7fffffff, 32'sh7fffffff});
        pending_coords.push_back('{32'sh80000000, 32'sh80000000});
        pending_coords.push_back('{-32'sh1, 32'sh1});
        pending_coords.push_back('{32'sh12345678, -32'sh12345678});
        drain();
        write_reg(hvn_pkg::REG_FREQ, 64'h0);
        write_reg(hvn_pkg::REG_SALT, 64'h7fff_ffff);
        pending_coords.push_back('{32'sh7fffffff, 32'sh80000000});
        pending_coords.push_back('{32'sh1234, 32'sh5678});
        drain();

        seeds = '{64'h0, 64'hffff_ffff_ffff_ffff, {$urandom(), $urandom()}, 64'h1};
        salts = '{64'h0, 64'h8000_0000, 64'h7fff_ffff, {32'd0, $urandom()}};
        freqs = '{64'd65536, 64'hff_ffff, 64'd1, {40'd0, 24'($urandom())}};
        for (int ph = 0; ph < 4; ph++)
        begin
            write_reg(hvn_pkg::REG_SEED, seeds[ph]);
            write_reg(hvn_pkg::REG_SALT, salts[ph]);
            write_reg(hvn_pkg::REG_FREQ, freqs[ph]);
            for (int i = 0; i < 270; i++)
                pending_coords.push_back('{rand_coord(), rand_coord()});
            if (ph == 1)
            begin
                hold_request = 1;
                @(posedge clk);
                @(posedge clk);
                hold_request = 0;
            end
            drain();
        end

        $display("checked %0d samples over several seed/salt/frequency settings,",
                 checked);
        $display("including extreme coordinates and a long output hold-off");
        if (errors == 0)
            $display("** hashed_value_noise_2d_core: PASSED **");
        else
            $display("** hashed_value_noise_2d_core: FAILED **");
        $finish;
    end
endmodule
